### rtl/poly_voice_allocator_midi_core_assert.svh
// Assertion macros for the voice allocator core.
`ifndef POLY_VOICE_ALLOCATOR_MIDI_CORE_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_MIDI_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PVAM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voice allocator check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PVAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voice allocator check failed");

`endif

### rtl/pvam_pkg.sv
// Types, constants, microcode table and lookup functions of the voice allocator.
package pvam_pkg;

    localparam int VOICES = 8;
    localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    localparam logic [1:0] OP_PAD      = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;

    localparam logic [1:0] REG_POLY_MODE   = 2'd0;
    localparam logic [1:0] REG_VOICE_CHANS = 2'd1;
    localparam logic [1:0] REG_LEVEL_CC    = 2'd2;
    localparam logic [1:0] REG_SPEED_CC    = 2'd3;

    localparam logic [31:0] VOICE_CHANS_RST = 32'h7654_3210;
    localparam logic [6:0]  LEVEL_CC_RST    = 7'd7;
    localparam logic [6:0]  SPEED_CC_RST    = 7'd43;

    localparam logic [6:0] TRIG_NOTE    = 7'd42;
    localparam logic [6:0] TRIG_VEL     = 7'd127;
    localparam logic [6:0] LEVEL_UP     = 7'd127;
    localparam logic [6:0] LEVEL_ZERO   = 7'd0;
    localparam logic [6:0] NOTE_LO      = 7'd36;
    localparam logic [6:0] NOTE_HI      = 7'd85;
    localparam logic [6:0] SPEED_CENTER = 7'd64;

    localparam int SPEED_DEPTH = 50;
    localparam int SPEED_IDX_W = $clog2(SPEED_DEPTH);

    // centre value plus pitch offset, one entry per note from NOTE_LO up
    localparam logic [6:0] SPEED_TABLE [0:SPEED_DEPTH-1] = '{
        7'd16,  7'd17,  7'd19,  7'd20,  7'd21,  7'd23,  7'd24,  7'd25,  7'd27,  7'd28,
        7'd29,  7'd31,  7'd32,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,  7'd48,  7'd51,
        7'd53,  7'd56,  7'd59,  7'd62,  7'd64,  7'd66,  7'd69,  7'd72,  7'd75,  7'd77,
        7'd80,  7'd82,  7'd85,  7'd88,  7'd91,  7'd94,  7'd96,  7'd97,  7'd99,  7'd100,
        7'd101, 7'd103, 7'd104, 7'd105, 7'd107, 7'd108, 7'd109, 7'd111, 7'd112, 7'd113
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LEVEL_ON,
        ST_SPEED,
        ST_TRIG,
        ST_LEVEL_OFF
    } step_t;

    typedef enum logic [2:0] {
        MSG_NONE,
        MSG_TRIG,
        MSG_LEVEL_ON,
        MSG_LEVEL_OFF,
        MSG_SPEED
    } msg_sel_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_IF_OUT
    } last_sel_t;

    typedef enum logic [1:0] {
        SLOT_KEEP,
        SLOT_TAKE,
        SLOT_FREE
    } slot_op_t;

    typedef enum logic [1:0] {
        SEQ_WAIT_IN,
        SEQ_DISPATCH,
        SEQ_GOTO,
        SEQ_IF_RANGE
    } seq_t;

    typedef struct packed {
        msg_sel_t  msg;
        last_sel_t last;
        slot_op_t  slot_op;
        logic      ld_voice;
        seq_t      seq;
        step_t     target;
    } ctrl_t;

    function automatic ctrl_t ucode(step_t step);
        ctrl_t w;
        w = '{MSG_NONE, LAST_NO, SLOT_KEEP, 1'b0, SEQ_WAIT_IN, ST_DISPATCH};
        unique case (step)
            ST_IDLE:      w = '{MSG_NONE, LAST_NO, SLOT_KEEP, 1'b0, SEQ_WAIT_IN, ST_DISPATCH};
            ST_DISPATCH:  w = '{MSG_NONE, LAST_NO, SLOT_KEEP, 1'b1, SEQ_DISPATCH, ST_IDLE};
            ST_LEVEL_ON:  w = '{MSG_LEVEL_ON, LAST_IF_OUT, SLOT_TAKE, 1'b0, SEQ_IF_RANGE,
                                ST_SPEED};
            ST_SPEED:     w = '{MSG_SPEED, LAST_NO, SLOT_KEEP, 1'b0, SEQ_GOTO, ST_TRIG};
            ST_TRIG:      w = '{MSG_TRIG, LAST_YES, SLOT_KEEP, 1'b0, SEQ_GOTO, ST_IDLE};
            ST_LEVEL_OFF: w = '{MSG_LEVEL_OFF, LAST_YES, SLOT_FREE, 1'b0, SEQ_GOTO, ST_IDLE};
            default:      w = '{MSG_NONE, LAST_NO, SLOT_KEEP, 1'b0, SEQ_GOTO, ST_IDLE};
        endcase
        return w;
    endfunction

    // first step of the routine for an event
    function automatic step_t dispatch(logic [1:0] op, logic poly, logic has_free,
                                       logic has_match, logic in_range);
        step_t s;
        s = ST_IDLE;
        unique case (op)
            OP_PAD:      s = ST_TRIG;
            OP_NOTE_ON:
            begin
                if (poly)
                    s = has_free ? ST_LEVEL_ON : ST_IDLE;
                else
                    s = in_range ? ST_SPEED : ST_IDLE;
            end
            OP_NOTE_OFF: s = (poly && has_match) ? ST_LEVEL_OFF : ST_IDLE;
            default:     s = ST_IDLE;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] speed_of(logic [6:0] note);
        logic [6:0] idx;
        idx = note - NOTE_LO;
        if (note >= NOTE_LO && idx < 7'(SPEED_DEPTH))
            return SPEED_TABLE[idx[SPEED_IDX_W-1:0]];
        else
            return SPEED_CENTER;
    endfunction

endpackage

### rtl/poly_voice_allocator_midi_core.sv
// Voice allocator core: event decode, slot table and MIDI message sequencer.
//
//  channel   | dir | handshake                    | contents
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | event: tuser op, tdata voice, note
//  m_axis    | out | m_axis_tvalid / m_axis_tready | message: tuser kind, tdata, tlast
//  apb       | in  | psel, penable, pready (high)  | four config registers at 4*i
//
//  An event is accepted, then dispatched, then takes one sequencer step per message
//  through the single output register; an event with no message ends at dispatch.
//  Reset clears the slot table valid bits, the step counter and the output valid.
//  A message step holds while the output register is full and not taken downstream;
//  a new event is taken only once the step counter is back at idle.
module poly_voice_allocator_midi_core
    import pvam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // voice[2:0], note[9:3], zero[15:10]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // number[6:0], amount[13:7], channel[17:14], zero
    output logic        m_axis_tuser,   // msg_kind[0]
    output logic        m_axis_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "poly_voice_allocator_midi_core_assert.svh"

    // configuration
    logic        poly_mode_reg, poly_mode_next;
    logic [31:0] voice_chans_reg, voice_chans_next;
    logic [6:0]  level_cc_reg, level_cc_next;
    logic [6:0]  speed_cc_reg, speed_cc_next;
    logic        cfg_write;

    // sequencer and event registers
    step_t       step_reg, step_next;
    ctrl_t       ctrl;
    logic [1:0]  op_reg, op_next;
    logic [2:0]  in_voice_reg, in_voice_next;
    logic [6:0]  note_reg, note_next;
    logic [2:0]  voice_reg, voice_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // slot table
    logic [VOICES-1:0] used_reg, used_next;
    logic [6:0]  notes_reg [VOICES];
    logic [6:0]  notes_next [VOICES];
    logic              has_free, has_match;
    logic [SLOT_W-1:0] free_idx, match_idx;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [17:0] m_data_reg, m_data_next;
    logic        m_kind_reg, m_kind_next;
    logic        m_last_reg, m_last_next;

    logic        in_accept, out_free, advance, msg_fire, in_range;
    logic        msg_kind;
    logic [6:0]  msg_number, msg_amount;
    logic [3:0]  msg_chan;
    logic        msg_last;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_POLY_MODE:   prdata = {31'd0, poly_mode_reg};
            REG_VOICE_CHANS: prdata = voice_chans_reg;
            REG_LEVEL_CC:    prdata = {25'd0, level_cc_reg};
            REG_SPEED_CC:    prdata = {25'd0, speed_cc_reg};
        endcase
    end

    always_comb
    begin
        poly_mode_next   = poly_mode_reg;
        voice_chans_next = voice_chans_reg;
        level_cc_next    = level_cc_reg;
        speed_cc_next    = speed_cc_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_POLY_MODE:   poly_mode_next   = pwdata[0];
                REG_VOICE_CHANS: voice_chans_next = pwdata;
                REG_LEVEL_CC:    level_cc_next    = pwdata[6:0];
                REG_SPEED_CC:    speed_cc_next    = pwdata[6:0];
            endcase
        end
    end

    assign ctrl          = ucode(step_reg);
    assign s_axis_tready = (step_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign advance       = (ctrl.msg == MSG_NONE) || out_free;
    assign msg_fire      = (ctrl.msg != MSG_NONE) && out_free;
    assign in_range      = (note_reg >= NOTE_LO) && (note_reg <= NOTE_HI);

    // lowest free slot and lowest slot holding the event's note
    always_comb
    begin
        has_free  = 1'b0;
        has_match = 1'b0;
        free_idx  = '0;
        match_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                has_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
            if (used_reg[i] && notes_reg[i] == note_reg)
            begin
                has_match = 1'b1;
                match_idx = SLOT_W'(i);
            end
        end
    end

    // next step
    always_comb
    begin
        step_next = step_reg;
        unique case (ctrl.seq)
            SEQ_WAIT_IN:
            begin
                if (in_accept)
                    step_next = ctrl.target;
            end
            SEQ_DISPATCH:
                step_next = dispatch(op_reg, poly_mode_reg, has_free, has_match, in_range);
            SEQ_GOTO:
            begin
                if (advance)
                    step_next = ctrl.target;
            end
            SEQ_IF_RANGE:
            begin
                if (advance)
                    step_next = in_range ? ctrl.target : ST_IDLE;
            end
        endcase
    end

    // datapath driven by the control word
    always_comb
    begin
        op_next       = op_reg;
        in_voice_next = in_voice_reg;
        note_next     = note_reg;
        voice_next    = voice_reg;
        slot_next     = slot_reg;
        used_next     = used_reg;
        notes_next    = notes_reg;

        if (in_accept)
        begin
            op_next       = s_axis_tuser;
            in_voice_next = s_axis_tdata[2:0];
            note_next     = s_axis_tdata[9:3];
        end

        if (ctrl.ld_voice)
        begin
            slot_next = (op_reg == OP_NOTE_ON) ? free_idx : match_idx;
            if (poly_mode_reg && op_reg == OP_NOTE_ON)
                voice_next = 3'(free_idx);
            else if (poly_mode_reg && op_reg == OP_NOTE_OFF)
                voice_next = 3'(match_idx);
            else
                voice_next = in_voice_reg;
        end

        for (int i = 0; i < VOICES; i++)
        begin
            if (msg_fire && slot_reg == SLOT_W'(i))
            begin
                unique case (ctrl.slot_op)
                    SLOT_TAKE:
                    begin
                        used_next[i]  = 1'b1;
                        notes_next[i] = note_reg;
                    end
                    SLOT_FREE: used_next[i] = 1'b0;
                    default:;
                endcase
            end
        end
    end

    // message fields
    always_comb
    begin
        msg_kind   = 1'b1;
        msg_number = level_cc_reg;
        msg_amount = LEVEL_UP;
        unique case (ctrl.msg)
            MSG_TRIG:
            begin
                msg_kind   = 1'b0;
                msg_number = TRIG_NOTE;
                msg_amount = TRIG_VEL;
            end
            MSG_LEVEL_OFF: msg_amount = LEVEL_ZERO;
            MSG_SPEED:
            begin
                msg_number = speed_cc_reg;
                msg_amount = speed_of(note_reg);
            end
            default:;
        endcase

        msg_chan = 4'(voice_chans_reg >> {voice_reg, 2'b00});

        unique case (ctrl.last)
            LAST_YES:    msg_last = 1'b1;
            LAST_IF_OUT: msg_last = !in_range;
            default:     msg_last = 1'b0;
        endcase
    end

    // output register: load on a message step, drop once taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_kind_next  = m_kind_reg;
        m_last_next  = m_last_reg;
        if (msg_fire)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {msg_chan, msg_amount, msg_number};
            m_kind_next  = msg_kind;
            m_last_next  = msg_last;
        end
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, m_data_reg};
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_mode_reg   <= 1'b0;
            voice_chans_reg <= VOICE_CHANS_RST;
            level_cc_reg    <= LEVEL_CC_RST;
            speed_cc_reg    <= SPEED_CC_RST;
            step_reg        <= ST_IDLE;
            used_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            poly_mode_reg   <= poly_mode_next;
            voice_chans_reg <= voice_chans_next;
            level_cc_reg    <= level_cc_next;
            speed_cc_reg    <= speed_cc_next;
            step_reg        <= step_next;
            used_reg        <= used_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        in_voice_reg <= in_voice_next;
        note_reg     <= note_next;
        voice_reg    <= voice_next;
        slot_reg     <= slot_next;
        notes_reg    <= notes_next;
        m_data_reg   <= m_data_next;
        m_kind_reg   <= m_kind_next;
        m_last_reg   <= m_last_next;
    end

    `PVAM_ASSERT_NEXT(a_accept_dispatch, in_accept, step_reg == ST_DISPATCH)
    `PVAM_ASSERT_IMP(a_take_free_slot, msg_fire && ctrl.slot_op == SLOT_TAKE,
                     !used_reg[slot_reg])
    `PVAM_ASSERT_IMP(a_free_used_slot, msg_fire && ctrl.slot_op == SLOT_FREE,
                     used_reg[slot_reg] && notes_reg[slot_reg] == note_reg)
    `PVAM_ASSERT_NEXT(a_trigger_last, msg_fire && step_reg == ST_TRIG,
                      m_axis_tvalid && m_axis_tlast)

endmodule
